[sv/psnp_pkg.sv]
package psnp_pkg;

   localparam int VALUE_BITS = 17;
   localparam int WORD_BITS  = 32;
   localparam int WORD_LOG   = 5;

   localparam logic FUNC_BUILD = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_BUILT = 2'd1;
   localparam logic [1:0] STATUS_NONE      = 2'd2;

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_CLEAR    = 9'b000000010,
      ST_SQUARE   = 9'b000000100,
      ST_TEST     = 9'b000001000,
      ST_TEST_CHK = 9'b000010000,
      ST_MARK_RD  = 9'b000100000,
      ST_MARK_WR  = 9'b001000000,
      ST_SCAN     = 9'b010000000,
      ST_DONE     = 9'b100000000
   } state_type;

   typedef struct packed {
      logic                found;
      logic [WORD_LOG-1:0] pos;
   } find_res_type;

endpackage

[sv/prime_sieve_next_prime.sv]
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  req_func, req_value
// rsp_      out        rsp_valid / rsp_stall  rsp_status, rsp_next_prime, rsp_distance
//
// A query answered without the map (map not built, a value of two or less, or a value past the
// map) passes through ST_DONE into the response registers; a scanning query reads one 32-bit
// map word after another until it finds a prime or has read the last word.
// A build clears the map word by word, then squares each odd number whose square is below
// LIMIT and tests it, and for each such number that is prime reads and writes back one map
// word for each mark.
// Reset is synchronous; after it queries report the map as not built.
// A new request is taken while a finished response still waits under rsp_stall.
module prime_sieve_next_prime #(
   parameter int LIMIT = 131072
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_func,
   input  logic [psnp_pkg::VALUE_BITS-1:0]   req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic [psnp_pkg::VALUE_BITS-1:0]   rsp_next_prime,
   output logic [psnp_pkg::VALUE_BITS-1:0]   rsp_distance
);
   import psnp_pkg::*;

   // Only odd numbers are stored: entry k stands for 2k+1.
   localparam int NODD      = LIMIT / 2;
   localparam int NWORDS    = (NODD + WORD_BITS - 1) / WORD_BITS;
   localparam int LAST_BITS = NODD - WORD_BITS * (NWORDS - 1);
   localparam int AW        = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int IW        = ($clog2(LIMIT) + 1) / 2 + 2;
   localparam int SQW       = 2 * IW;
   localparam int CW        = (SQW > VALUE_BITS) ? SQW : VALUE_BITS;

   state_type              state_ff, state_in;
   logic                   map_built_ff, map_built_in;
   logic [IW-1:0]          i_ff, i_in;
   logic [SQW-1:0]         sq_ff, sq_in;
   logic [SQW-1:0]         kj_ff, kj_in;
   logic [AW-1:0]          wa_ff, wa_in;
   logic [WORD_LOG-1:0]    lo_ff, lo_in;
   logic [AW-1:0]          clr_ff, clr_in;
   logic [VALUE_BITS-1:0]  value_ff, value_in;
   logic [1:0]             res_status_ff, res_status_in;
   logic [VALUE_BITS-1:0]  res_prime_ff, res_prime_in;
   logic [VALUE_BITS-1:0]  res_dist_ff, res_dist_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic [VALUE_BITS-1:0]  rsp_next_prime_ff, rsp_next_prime_in;
   logic [VALUE_BITS-1:0]  rsp_distance_ff, rsp_distance_in;

   logic [WORD_BITS-1:0]   map_mem [NWORDS];
   logic [WORD_BITS-1:0]   rd_data_ff;
   logic                   rd_en, wr_en;
   logic [AW-1:0]          rd_addr, wr_addr;
   logic [WORD_BITS-1:0]   wr_data;

   logic [CW-1:0]          kq;
   logic [SQW-1:0]         ki;
   logic [WORD_LOG:0]      scan_cnt;
   find_res_type           find_res;
   logic [AW+WORD_LOG-1:0] found_k;
   logic [VALUE_BITS-1:0]  found_prime;

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_next_prime = rsp_next_prime_ff;
   assign rsp_distance   = rsp_distance_ff;

   assign kq       = CW'(req_value >> 1);
   assign ki       = SQW'(i_ff >> 1);
   assign scan_cnt = (wa_ff == AW'(NWORDS - 1)) ? (WORD_LOG + 1)'(LAST_BITS)
                                                : (WORD_LOG + 1)'(WORD_BITS);
   assign found_k     = {wa_ff, find_res.pos};
   assign found_prime = VALUE_BITS'({found_k, 1'b1});

   psnp_find u_find (
      .word (rd_data_ff),
      .lo   (lo_ff),
      .cnt  (scan_cnt),
      .res  (find_res)
   );

   always_comb begin
      state_in          = state_ff;
      map_built_in      = map_built_ff;
      i_in              = i_ff;
      sq_in             = sq_ff;
      kj_in             = kj_ff;
      wa_in             = wa_ff;
      lo_in             = lo_ff;
      clr_in            = clr_ff;
      value_in          = value_ff;
      res_status_in     = res_status_ff;
      res_prime_in      = res_prime_ff;
      res_dist_in       = res_dist_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_status_in     = rsp_status_ff;
      rsp_next_prime_in = rsp_next_prime_ff;
      rsp_distance_in   = rsp_distance_ff;
      rd_en             = 1'b0;
      rd_addr           = '0;
      wr_en             = 1'b0;
      wr_addr           = '0;
      wr_data           = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               value_in      = req_value;
               res_status_in = STATUS_OK;
               res_prime_in  = '0;
               res_dist_in   = '0;
               if (req_func == FUNC_BUILD) begin
                  clr_in   = '0;
                  state_in = ST_CLEAR;
               end else if (!map_built_ff) begin
                  res_status_in = STATUS_NOT_BUILT;
                  state_in      = ST_DONE;
               end else if (req_value <= VALUE_BITS'(2)) begin
                  res_prime_in = VALUE_BITS'(2);
                  res_dist_in  = VALUE_BITS'(2) - req_value;
                  state_in     = ST_DONE;
               end else if (kq >= CW'(NODD)) begin
                  res_status_in = STATUS_NONE;
                  state_in      = ST_DONE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = kq[AW+WORD_LOG-1:WORD_LOG];
                  wa_in    = kq[AW+WORD_LOG-1:WORD_LOG];
                  lo_in    = kq[WORD_LOG-1:0];
                  state_in = ST_SCAN;
               end
            end
         end
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == AW'(NWORDS - 1)) begin
               i_in     = IW'(3);
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            sq_in    = SQW'(i_ff) * SQW'(i_ff);
            state_in = ST_TEST;
         end
         ST_TEST: begin
            if (sq_ff >= SQW'(LIMIT)) begin
               map_built_in = 1'b1;
               state_in     = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = ki[AW+WORD_LOG-1:WORD_LOG];
               state_in = ST_TEST_CHK;
            end
         end
         ST_TEST_CHK: begin
            if (rd_data_ff[ki[WORD_LOG-1:0]]) begin
               i_in     = i_ff + IW'(2);
               state_in = ST_SQUARE;
            end else begin
               kj_in    = sq_ff >> 1;
               state_in = ST_MARK_RD;
            end
         end
         ST_MARK_RD: begin
            if (kj_ff >= SQW'(NODD)) begin
               i_in     = i_ff + IW'(2);
               state_in = ST_SQUARE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = kj_ff[AW+WORD_LOG-1:WORD_LOG];
               state_in = ST_MARK_WR;
            end
         end
         ST_MARK_WR: begin
            // The write lands before the next read, so marks in one word never collide.
            wr_en    = 1'b1;
            wr_addr  = kj_ff[AW+WORD_LOG-1:WORD_LOG];
            wr_data  = rd_data_ff | (WORD_BITS'(1) << kj_ff[WORD_LOG-1:0]);
            kj_in    = kj_ff + SQW'(i_ff);
            state_in = ST_MARK_RD;
         end
         ST_SCAN: begin
            if (find_res.found) begin
               res_prime_in = found_prime;
               res_dist_in  = found_prime - value_ff;
               state_in     = ST_DONE;
            end else if (wa_ff == AW'(NWORDS - 1)) begin
               res_status_in = STATUS_NONE;
               state_in      = ST_DONE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = wa_ff + AW'(1);
               wa_in   = wa_ff + AW'(1);
               lo_in   = '0;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_status_in     = res_status_ff;
               rsp_next_prime_in = res_prime_ff;
               rsp_distance_in   = res_dist_ff;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         map_built_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         map_built_ff <= map_built_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff              <= i_in;
      sq_ff             <= sq_in;
      kj_ff             <= kj_in;
      wa_ff             <= wa_in;
      lo_ff             <= lo_in;
      clr_ff            <= clr_in;
      value_ff          <= value_in;
      res_status_ff     <= res_status_in;
      res_prime_ff      <= res_prime_in;
      res_dist_ff       <= res_dist_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_next_prime_ff <= rsp_next_prime_in;
      rsp_distance_ff   <= rsp_distance_in;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= map_mem[rd_addr];
      end
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
   end

`ifndef NO_ASSERTIONS
   a_map_write_in_build: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_CLEAR || state_ff == ST_MARK_WR))
      else $error("map written outside a build");

   a_scan_needs_map: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> map_built_ff)
      else $error("scan started on a map that was never built");

   a_prime_is_odd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_OK && rsp_next_prime != '0)
      |-> (rsp_next_prime[0] || rsp_next_prime == VALUE_BITS'(2)))
      else $error("response prime is even and not two");

   a_done_follows_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_DONE))
      else $error("response raised without a finished request");
`endif

endmodule

[sv/psnp_find.sv]
module psnp_find (
   input  logic [psnp_pkg::WORD_BITS-1:0] word,
   input  logic [psnp_pkg::WORD_LOG-1:0]  lo,
   input  logic [psnp_pkg::WORD_LOG:0]    cnt,
   output psnp_pkg::find_res_type         res
);
   import psnp_pkg::*;

   logic [WORD_BITS-1:0] cand;

   // A candidate is a prime flag (bit clear) inside the window [lo, cnt).
   always_comb begin
      for (int p = 0; p < WORD_BITS; p++) begin
         cand[p] = !word[p] && (WORD_LOG'(p) >= lo) && ((WORD_LOG + 1)'(p) < cnt);
      end
   end

   always_comb begin
      res.found = 1'b0;
      res.pos   = '0;
      for (int p = WORD_BITS - 1; p >= 0; p--) begin
         if (cand[p]) begin
            res.found = 1'b1;
            res.pos   = WORD_LOG'(p);
         end
      end
   end

endmodule

[bench/prime_sieve_next_prime_tb.sv]
`timescale 1ns / 100ps

module prime_sieve_next_prime_tb;
   import psnp_pkg::*;

   localparam int SIEVE_LIMIT    = 131072;
   localparam int RANDOM_ITEMS   = 930;
   localparam int IDLE_PERCENT   = 27;
   localparam int SEND_CALM_FROM = 450;
   localparam int SEND_CALM_TO   = 600;
   localparam int TAKE_CALM_FROM = 470;
   localparam int TAKE_CALM_TO   = 620;
   localparam int HOLD_AT        = 350;
   localparam int HOLD_CYCLES    = 250;
   localparam int DRAIN_CYCLES   = 200;
   localparam int PRINT_LIMIT    = 50;
   localparam int WATCHDOG_LIMIT = 1000000;

   typedef logic [VALUE_BITS-1:0] value_type;

   typedef struct packed {
      logic [1:0] status;
      value_type  next_prime;
      value_type  distance;
   } prime_answer_type;

   typedef struct packed {
      logic             func;
      value_type        value;
      logic             typed;
      prime_answer_type answer;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic       req_func;
   value_type  req_value;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [1:0] rsp_status;
   value_type  rsp_next_prime;
   value_type  rsp_distance;

   bit               composite [SIEVE_LIMIT];
   bit               sieve_ready = 1'b0;
   prime_answer_type pending_answers [$];

   int error_count    = 0;
   int requests_sent  = 0;
   int response_count = 0;
   int builds_seen    = 0;
   int queries_seen   = 0;
   int early_queries  = 0;
   int widest_gap     = 0;
   int quiet_cycles   = 0;

   prime_sieve_next_prime #(
      .LIMIT(SIEVE_LIMIT)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_next_prime (rsp_next_prime),
      .rsp_distance   (rsp_distance)
   );

   always #4 clock = ~clock;

   function automatic prime_answer_type predict_answer(logic func, value_type value);
      prime_answer_type answer;
      int               n;
      answer = '0;
      if (func == FUNC_BUILD) begin
         builds_seen++;
         foreach (composite[k]) composite[k] = 1'b0;
         // Only odd numbers are ever looked up, so even multiples are never marked.
         for (int p = 3; p * p < SIEVE_LIMIT; p += 2) begin
            if (!composite[p]) begin
               for (int m = p * p; m < SIEVE_LIMIT; m += 2 * p) composite[m] = 1'b1;
            end
         end
         sieve_ready = 1'b1;
         return answer;
      end
      queries_seen++;
      if (!sieve_ready) begin
         early_queries++;
         answer.status = STATUS_NOT_BUILT;
         return answer;
      end
      if (value <= value_type'(2)) begin
         answer.next_prime = value_type'(2);
         answer.distance   = value_type'(2) - value;
         return answer;
      end
      n = int'(value) | 1;
      while (n < SIEVE_LIMIT && composite[n]) n += 2;
      if (n >= SIEVE_LIMIT) begin
         answer.status = STATUS_NONE;
      end else begin
         answer.next_prime = value_type'(n);
         answer.distance   = value_type'(n - int'(value));
      end
      return answer;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   task automatic offer_request(logic func, value_type value, logic typed,
                                prime_answer_type typed_answer);
      prime_answer_type predicted;
      while (!(requests_sent >= SEND_CALM_FROM && requests_sent < SEND_CALM_TO) &&
             $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= func;
      req_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = predict_answer(func, value);
      pending_answers.insert(pending_answers.size(), typed ? typed_answer : predicted);
      requests_sent++;
   endtask

   task automatic check_response();
      prime_answer_type want;
      response_count++;
      if (pending_answers.size() == 0) begin
         report_mismatch("status of a response with no request outstanding",
                         32'(rsp_status), '0);
         return;
      end
      want = pending_answers.pop_front();
      if (rsp_status !== want.status)
         report_mismatch("status", 32'(rsp_status), 32'(want.status));
      if (rsp_next_prime !== want.next_prime)
         report_mismatch("next_prime", 32'(rsp_next_prime), 32'(want.next_prime));
      if (rsp_distance !== want.distance)
         report_mismatch("distance", 32'(rsp_distance), 32'(want.distance));
      if (want.status == STATUS_OK && int'(want.distance) > widest_gap)
         widest_gap = int'(want.distance);
   endtask

   initial begin : response_side
      bit held;
      held = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) check_response();
         if (!held && response_count >= HOLD_AT) begin
            // A long hold-off lets the block fill up and push back on requests.
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (response_count >= TAKE_CALM_FROM && response_count < TAKE_CALM_TO)
            rsp_stall <= 1'b0;
         else
            rsp_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, giving up", $time, quiet_cycles);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : request_side
      stim_row_type directed_rows [20];
      int           build_at;
      int           pick;
      value_type    value;

      directed_rows = '{
         '{FUNC_QUERY, 17'd0,      1'b1, '{STATUS_NOT_BUILT, 17'd0,      17'd0}},
         '{FUNC_QUERY, 17'd131071, 1'b1, '{STATUS_NOT_BUILT, 17'd0,      17'd0}},
         '{FUNC_BUILD, 17'd0,      1'b1, '{STATUS_OK,        17'd0,      17'd0}},
         '{FUNC_QUERY, 17'd0,      1'b1, '{STATUS_OK,        17'd2,      17'd2}},
         '{FUNC_QUERY, 17'd1,      1'b1, '{STATUS_OK,        17'd2,      17'd1}},
         '{FUNC_QUERY, 17'd2,      1'b1, '{STATUS_OK,        17'd2,      17'd0}},
         '{FUNC_QUERY, 17'd3,      1'b1, '{STATUS_OK,        17'd3,      17'd0}},
         '{FUNC_QUERY, 17'd4,      1'b1, '{STATUS_OK,        17'd5,      17'd1}},
         '{FUNC_QUERY, 17'd9,      1'b0, '0},
         '{FUNC_QUERY, 17'd24,     1'b0, '0},
         '{FUNC_QUERY, 17'd361,    1'b0, '0},
         '{FUNC_QUERY, 17'd128881, 1'b0, '0},
         '{FUNC_QUERY, 17'd31398,  1'b0, '0},
         '{FUNC_QUERY, 17'd65536,  1'b0, '0},
         '{FUNC_QUERY, 17'd131070, 1'b1, '{STATUS_OK,        17'd131071, 17'd1}},
         '{FUNC_QUERY, 17'd131071, 1'b1, '{STATUS_OK,        17'd131071, 17'd0}},
         '{FUNC_BUILD, 17'd131071, 1'b1, '{STATUS_OK,        17'd0,      17'd0}},
         '{FUNC_QUERY, 17'd131071, 1'b1, '{STATUS_OK,        17'd131071, 17'd0}},
         '{FUNC_QUERY, 17'd100,    1'b0, '0},
         '{FUNC_QUERY, 17'd1,      1'b1, '{STATUS_OK,        17'd2,      17'd1}}
      };

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_func  <= FUNC_QUERY;
      req_value <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r])
         offer_request(directed_rows[r].func, directed_rows[r].value,
                       directed_rows[r].typed, directed_rows[r].answer);

      // A build costs a full sieve pass, so the random part carries only one.
      build_at = $urandom_range(650, 800);
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 15)
            value = value_type'($urandom_range(0, 40));
         else if (pick < 30)
            value = value_type'($urandom_range(130900, 131071));
         else if (pick < 45)
            value = value_type'($urandom_range(0, 65535) * 2);
         else if (pick < 55)
            value = value_type'($urandom_range(31390, 31470));
         else
            value = value_type'($urandom_range(0, 131071));
         offer_request(k == build_at ? FUNC_BUILD : FUNC_QUERY, value, 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d builds and %0d queries, %0d of them before the first build.",
               builds_seen, queries_seen, early_queries);
      $display("Widest prime gap returned was %0d; %0d responses taken, %0d mismatches.",
               widest_gap, response_count, error_count);
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

[sim.f]
sv/psnp_pkg.sv
sv/psnp_find.sv
sv/prime_sieve_next_prime.sv
bench/prime_sieve_next_prime_tb.sv
